[design/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, mode codes and character constants for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // mode codes on the func field
    localparam logic [1:0] FUNC_SDEC    = 2'd0;
    localparam logic [1:0] FUNC_HEX     = 2'd2;
    localparam logic [1:0] FUNC_HEX_ALT = 2'd3;  // unused code, decoded as hex

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWA  = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [3:0] DIGIT_TEN = 4'd10;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture magnitude and flags
        logic shift;      // one double-dabble step
        logic adv;        // drop the top digit
        logic put_sign;   // output register <= '-'
        logic put_digit;  // output register <= top digit
        logic put_last;   // last flag for put_digit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic neg;
        logic top_zero;
    } sts_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {4'd0, d};
        end else begin
            c = CHAR_LOWA + {4'd0, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

[design/itoa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: takes a word, runs the binary to BCD steps if decimal, skips
// leading zero digits, then hands out sign and digits via the output register.
// ----------------------------------------------------------------------------
module itoa_ctrl #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       s_func,
    output logic             m_tvalid,
    input  logic             m_tready,
    output itoa_pkg::cmd_t   cmd,
    input  itoa_pkg::sts_t   sts
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam int RW = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT,
        S_DRAIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic            valid_reg, valid_next;
    logic            hex_in;
    logic            rem_one;

    assign hex_in  = (s_func == itoa_pkg::FUNC_HEX) || (s_func == itoa_pkg::FUNC_HEX_ALT);
    assign rem_one = (rem_reg == RW'(1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    rem_next   = RW'(NDIG);
                    cnt_next   = CW'(VALUE_WIDTH);
                    state_next = hex_in ? S_SKIP : S_CONV;
                end
            end
            S_CONV: begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = S_SKIP;
                end
            end
            S_SKIP: begin
                // always keep at least one digit so zero prints as '0'
                if (sts.top_zero && !rem_one) begin
                    cmd.adv  = 1'b1;
                    rem_next = rem_reg - RW'(1);
                end else begin
                    if (sts.neg) begin
                        cmd.put_sign = 1'b1;
                        valid_next   = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!valid_reg || m_tready) begin
                    cmd.put_digit = 1'b1;
                    cmd.adv       = 1'b1;
                    cmd.put_last  = rem_one;
                    valid_next    = 1'b1;
                    rem_next      = rem_reg - RW'(1);
                    if (rem_one) begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule

[design/itoa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude and sign capture, shift-and-add-3 BCD converter,
// digit shift register and the character output register.
// ----------------------------------------------------------------------------
module itoa_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                   aclk,
    input  logic [1:0]             s_func,
    input  logic [VALUE_WIDTH-1:0] s_value,
    input  itoa_pkg::cmd_t         cmd,
    output itoa_pkg::sts_t         sts,
    output logic [7:0]             m_char,
    output logic                   m_last
);

    localparam int DW = NDIG * 4;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [DW-1:0]          bcd_reg;
    logic                   neg_reg;
    logic [7:0]             char_reg;
    logic                   last_reg;

    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag;
    logic [DW-1:0]          bcd_adj;
    logic [3:0]             top_digit;

    assign neg_in = (s_func == itoa_pkg::FUNC_SDEC) && s_value[VALUE_WIDTH-1];
    // unsigned magnitude, so the most negative value comes out exact
    assign mag    = neg_in ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign top_digit = bcd_reg[DW-1 -: 4];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg <= neg_in;
            if (s_func[1]) begin
                bin_reg <= '0;
                bcd_reg <= {{(DW-VALUE_WIDTH){1'b0}}, mag};
            end else begin
                bin_reg <= mag;
                bcd_reg <= '0;
            end
        end else if (cmd.shift) begin
            bcd_reg <= {bcd_adj[DW-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_reg <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end else if (cmd.adv) begin
            bcd_reg <= {bcd_reg[DW-5:0], 4'h0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put_sign) begin
            char_reg <= itoa_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.put_digit) begin
            char_reg <= itoa_pkg::digit_to_ascii(top_digit);
            last_reg <= cmd.put_last;
        end
    end

    assign sts.neg      = neg_reg;
    assign sts.top_zero = (top_digit == 4'd0);
    assign m_char       = char_reg;
    assign m_last       = last_reg;

endmodule

[design/integer_to_ascii_formatter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one word as signed decimal, unsigned decimal or lowercase hex ASCII,
// most significant character first, tlast on the final character.
// ----------------------------------------------------------------------------
// Sequence: decimal words run the BCD loop after accept, hex words do not; then
// each leading zero digit is dropped, and a leading '-' is shown before the first
// digit. Then one character per cycle while m_tready is high.
// One word at a time: s_tready returns after the last character is taken; the
// VALUE_WIDTH-step shift-and-add-3 BCD loop sets the decimal cost.
// Reset: synchronous, active low aresetn; no word in flight, outputs empty.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // func [1:0], value [VALUE_WIDTH+1:2], zero pad above
    input  logic [((VALUE_WIDTH + 2 + 7) / 8)*8-1:0] s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // char_out [7:0]
    output logic [7:0]                              m_tdata,
    output logic                                    m_tlast
);

    localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;

    itoa_pkg::cmd_t cmd;
    itoa_pkg::sts_t sts;

    itoa_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tdata[1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dp (
        .aclk    (aclk),
        .s_func  (s_tdata[1:0]),
        .s_value (s_tdata[VALUE_WIDTH+1:2]),
        .cmd     (cmd),
        .sts     (sts),
        .m_char  (m_tdata),
        .m_last  (m_tlast)
    );

endmodule

[design/itoa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // output register is empty once reset is seen
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a new word is only taken with nothing pending on the output
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("s_tready while output pending");

    // after a word is taken, the block is busy and has no character yet
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("not busy after accept");

    // only digits, a..f and '-' come out
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= 8'h30 && m_tdata <= 8'h39) ||
                      (m_tdata >= 8'h61 && m_tdata <= 8'h66) ||
                      (m_tdata == 8'h2D)))
        else $error("illegal character");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled word changed");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[bench/integer_to_ascii_formatter_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_checker
// Watches both stream channels of the formatter, predicts the character
// sequence of every accepted input word and compares each output word
// against it.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_checker #(
    parameter int VALUE_WIDTH = 32,
    parameter int TDATA_W     = ((VALUE_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,
    input  logic               m_tlast,
    output int                 error_count,
    output int                 chars_pending
);

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } char_item_t;

    char_item_t expected_chars[$];

    // Queue the characters of one word, most significant first.
    function automatic void format_word(input logic [1:0] func,
                                        input logic [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] base;
        logic [3:0]             digit;
        logic [7:0]             ch;
        logic                   negative;
        logic [7:0]             text[$];
        char_item_t             item;

        negative = (func == itoa_pkg::FUNC_SDEC) && value[VALUE_WIDTH-1];
        // unsigned negate, so the most negative value stays exact
        mag  = negative ? (~value + 1'b1) : value;
        base = (func == itoa_pkg::FUNC_HEX || func == itoa_pkg::FUNC_HEX_ALT) ? 16 : 10;
        do begin
            digit = 4'(mag % base);
            if (digit < itoa_pkg::DIGIT_TEN) begin
                ch = itoa_pkg::CHAR_ZERO + {4'd0, digit};
            end else begin
                ch = itoa_pkg::CHAR_LOWA + {4'd0, digit - itoa_pkg::DIGIT_TEN};
            end
            text.push_front(ch);
            mag = mag / base;
        end while (mag != 0);
        if (negative) begin
            text.push_front(itoa_pkg::CHAR_MINUS);
        end
        foreach (text[i]) begin
            item.char_out = text[i];
            item.last     = (i == text.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    always @(posedge aclk) begin : track
        char_item_t got;
        int         bad;

        bad = 0;
        if (!aresetn) begin
            expected_chars.delete();
            error_count   <= 0;
            chars_pending <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                format_word(s_tdata[1:0], s_tdata[VALUE_WIDTH+1:2]);
            end
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected word: char_out %h last %b", m_tdata, m_tlast);
                    bad++;
                end else begin
                    got = expected_chars.pop_front();
                    if (m_tdata !== got.char_out) begin
                        $error("char_out: expected %h actual %h", got.char_out, m_tdata);
                        bad++;
                    end
                    if (m_tlast !== got.last) begin
                        $error("last: expected %b actual %b", got.last, m_tlast);
                        bad++;
                    end
                end
            end
            error_count   <= error_count + bad;
            chars_pending <= expected_chars.size();
        end
    end

endmodule

[bench/integer_to_ascii_formatter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit_test
// Drives directed and random words into the formatter in all modes under
// three sender/receiver idling mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit_test;

    localparam int VALUE_WIDTH     = 32;
    localparam int TDATA_W         = ((VALUE_WIDTH + 2 + 7) / 8) * 8;
    localparam logic [1:0] FUNC_UDEC = 2'd1;
    localparam int WORDS_PER_PHASE = 134;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_TAIL      = 64;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // func [1:0], value [VALUE_WIDTH+1:2], zero pad above
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // char_out [7:0]
    logic [7:0]         m_tdata;
    logic               m_tlast;

    int tx_idle_pct = 23;
    int rx_idle_pct = 88;
    int error_count;
    int chars_pending;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    integer_to_ascii_formatter_unit #(.VALUE_WIDTH(VALUE_WIDTH)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    integer_to_ascii_formatter_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .error_count   (error_count),
        .chars_pending (chars_pending)
    );

    // valid stays high from one word to the next unless an idle cycle is rolled
    task automatic send_word(input logic [1:0] func, input logic [VALUE_WIDTH-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({value, func});
        do @(posedge aclk); while (!s_tready);
    endtask

    // extra edge first: chars_pending is registered, so it lags the accepting edge
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (chars_pending != 0) @(posedge aclk);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom_range(99);
            1: v = VALUE_WIDTH'(1) << $urandom_range(VALUE_WIDTH - 1);
            2: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}} + $urandom_range(7) - 4;
            3: v = '1 - $urandom_range(15);
            4: v = $urandom >> $urandom_range(31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("FAIL integer_to_ascii_formatter_unit");
        $finish;
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero in every mode, including the unused code
        send_word(itoa_pkg::FUNC_SDEC, '0);
        send_word(FUNC_UDEC, '0);
        send_word(itoa_pkg::FUNC_HEX, '0);
        send_word(itoa_pkg::FUNC_HEX_ALT, '0);
        // all ones in every mode, the most negative value in all but the unused code
        send_word(itoa_pkg::FUNC_SDEC, '1);
        send_word(FUNC_UDEC, '1);
        send_word(itoa_pkg::FUNC_HEX, '1);
        send_word(itoa_pkg::FUNC_HEX_ALT, '1);
        send_word(itoa_pkg::FUNC_SDEC, 32'h8000_0000);
        send_word(FUNC_UDEC, 32'h8000_0000);
        send_word(itoa_pkg::FUNC_HEX, 32'h8000_0000);
        send_word(itoa_pkg::FUNC_SDEC, 32'h7fff_ffff);
        send_word(itoa_pkg::FUNC_SDEC, 32'h8000_0001);
        send_word(itoa_pkg::FUNC_SDEC, 32'd1);
        send_word(FUNC_UDEC, 32'd9);
        send_word(FUNC_UDEC, 32'd10);
        send_word(itoa_pkg::FUNC_HEX, 32'd15);
        send_word(itoa_pkg::FUNC_HEX, 32'd16);
        send_word(itoa_pkg::FUNC_HEX_ALT, 32'hdead_beef);
        send_word(itoa_pkg::FUNC_HEX, 32'h0123_4567);
        send_word(FUNC_UDEC, 32'd1_000_000_000);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 88;
                end
                1: begin
                    tx_idle_pct = 88;
                    rx_idle_pct = 23;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if ($urandom_range(99) < 2) begin
                    wait_drained();
                end
                send_word(2'($urandom_range(3)), pick_value());
            end
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS integer_to_ascii_formatter_unit");
        end else begin
            $display("FAIL integer_to_ascii_formatter_unit");
        end
        $finish;
    end

endmodule
